>>> rtl/core/hed_pkg.sv
// Shared types and byte constants for the character reference decoder.
`timescale 1ns / 1ps

package hed_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_QUOT  = 8'h22;  // '"'
  localparam logic [7:0] CH_APOS  = 8'h27;  // single quote
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] NAME_LT   = "lt";
  localparam logic [15:0] NAME_GT   = "gt";
  localparam logic [23:0] NAME_AMP  = "amp";
  localparam logic [23:0] NAME_N39  = "#39";
  localparam logic [31:0] NAME_QUOT = "quot";
  localparam logic [31:0] NAME_APOS = "apos";
  localparam logic [31:0] NAME_NBSP = "nbsp";

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Command broadcast along the row of cells.
  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       append;
    logic       shift_in_valid;
    logic [7:0] shift_in_data;
    logic [7:0] append_data;
  } chain_cmd_t;

  // What the controller sees of the row and of the name lookup.
  typedef struct packed {
    logic       head_valid;
    logic       next_valid;
    logic       full;
    logic [7:0] head_data;
    logic [7:0] next_data;
    logic       match_hit;
    logic [7:0] match_byte;
  } chain_stat_t;

endpackage

>>> rtl/core/hed_cell.sv
// One holding cell of the reference buffer row.
`timescale 1ns / 1ps

module hed_cell (
  input  logic               clk,
  input  logic               rst,
  input  hed_pkg::chain_cmd_t cmd,
  input  logic               prev_valid,
  input  logic               right_valid,
  input  logic [7:0]         right_data,
  output logic               valid,
  output logic [7:0]         data
);
  import hed_pkg::*;

  // The first empty cell behind a filled one takes an appended byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.shift) begin
      valid <= right_valid;
    end else if (cmd.append && prev_valid && !valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      data <= right_data;
    end else if (cmd.append && prev_valid && !valid) begin
      data <= cmd.append_data;
    end
  end

endmodule

>>> rtl/core/hed_ctrl.sv
// Sequencer that takes input words and drains result words from the cell row and the tail register.
`timescale 1ns / 1ps

module hed_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_final,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_end,
  output logic                 text_end,
  input  hed_pkg::chain_stat_t stat,
  output hed_pkg::chain_cmd_t  cmd
);
  import hed_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [7:0] tail_byte;
  logic       tail_valid;
  logic       forced;
  logic       flush_all;
  logic       text_fin;

  logic       accept;
  logic       emit_go;
  logic       start;
  logic [7:0] setup_tail;
  logic       setup_tail_valid;
  logic       setup_forced;
  logic       setup_flush;
  logic [7:0] em_byte;
  logic       em_last;
  logic       em_tail;

  assign accept  = in_valid && in_ready;
  assign emit_go = (state == ST_DRAIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && start) state_next = ST_DRAIN;
      ST_DRAIN: if (emit_go && em_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready             = 1'b0;
    start                = 1'b0;
    setup_tail           = in_byte;
    setup_tail_valid     = 1'b0;
    setup_forced         = 1'b0;
    setup_flush          = 1'b1;
    em_byte              = tail_byte;
    em_last              = 1'b1;
    em_tail              = 1'b0;
    cmd                  = '0;
    cmd.append_data      = in_byte;
    cmd.shift_in_data    = tail_byte;
    cmd.shift_in_valid   = forced;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (!stat.head_valid) begin
          if (in_byte == CH_AMP) begin
            cmd.append = accept;
            start      = in_final;
          end else begin
            setup_tail_valid = 1'b1;
            start            = 1'b1;
          end
        end else if (in_byte == CH_SEMI) begin
          start            = 1'b1;
          setup_tail_valid = 1'b1;
          if (stat.match_hit) begin
            setup_tail = stat.match_byte;
            cmd.clear  = accept;
          end
        end else if (!stat.full) begin
          cmd.append = accept;
          start      = in_final;
        end else begin
          start        = 1'b1;
          setup_forced = 1'b1;
          setup_flush  = in_final;
        end
      end
      ST_DRAIN: begin
        if (forced) begin
          em_byte   = stat.head_data;
          em_last   = !flush_all && (stat.next_data == CH_AMP);
          cmd.shift = emit_go;
        end else if (stat.head_valid) begin
          em_byte   = stat.head_data;
          em_last   = flush_all ? !(stat.next_valid || tail_valid)
                                : !(stat.next_valid && (stat.next_data != CH_AMP));
          cmd.shift = emit_go;
        end else begin
          em_tail = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tail_valid <= 1'b0;
      forced     <= 1'b0;
      flush_all  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && start) begin
        tail_valid <= setup_tail_valid;
        forced     <= setup_forced;
        flush_all  <= setup_flush;
      end else if (emit_go) begin
        forced <= 1'b0;
        if (em_tail) tail_valid <= 1'b0;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start) begin
      tail_byte <= setup_tail;
      text_fin  <= in_final;
    end
    if (emit_go) begin
      out_byte <= em_byte;
      run_end  <= em_last;
      text_end <= em_last && text_fin;
    end
  end

endmodule

>>> rtl/core/html_entity_decoder_unit.sv
// Top level of the streaming HTML character reference decoder.
`timescale 1ns / 1ps

// Usage notes.
// Input words (in_byte, in_final) enter on a valid/ready channel; result words
// (out_byte, run_end, text_end) leave on a second valid/ready channel.
// An ampersand and the name bytes after it are held in a row of cells; a
// semicolon closes the reference and a known name is replaced by one byte.
// in_ready is high whenever the sequencer is idle. A word that is only held
// is stored in the cell row. A word that gives result words is taken first,
// then each result is shifted out of the head of the cell row or taken from
// the single tail register. Results are registered in the result register
// while the sequencer is in its drain state.
// run_end marks the last result of an input word, text_end additionally marks
// it when that word carried in_final.
// The result register sits between the two sides, so a new input word can be
// taken while the last result of the previous one waits for out_ready. When
// the receiver stalls, draining simply pauses with the held bytes in place.
// Reset empties the cell row, drops any pending output word and returns the
// sequencer to idle.

module html_entity_decoder_unit #(
  parameter int MAX_REF_SPAN = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       text_end
);
  import hed_pkg::*;

  // Padding so that the name lookup may look at fixed cell places even when
  // the row is shorter than the longest name.
  localparam int PAD_CELLS = 6;
  localparam int PAD_W     = MAX_REF_SPAN + PAD_CELLS;

  chain_cmd_t  cmd;
  chain_stat_t stat;

  logic [MAX_REF_SPAN-1:0]   cell_valid;
  logic [8*MAX_REF_SPAN-1:0] cell_flat;
  logic [MAX_REF_SPAN:0]     prev_vec;
  logic [MAX_REF_SPAN:0]     right_valid_vec;
  logic [8*MAX_REF_SPAN+7:0] right_data_vec;
  logic [PAD_W-1:0]          pad_valid;
  logic [8*PAD_W-1:0]        pad_data;

  // Each cell looks left for "the cell before me is filled" and right for the
  // byte it takes on a shift; the last cell takes the controller's shift input.
  assign prev_vec        = {cell_valid, 1'b1};
  assign right_valid_vec = {cmd.shift_in_valid, cell_valid};
  assign right_data_vec  = {cmd.shift_in_data, cell_flat};

  for (genvar i = 0; i < MAX_REF_SPAN; i++) begin : g_cell
    hed_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .prev_valid  (prev_vec[i]),
      .right_valid (right_valid_vec[i+1]),
      .right_data  (right_data_vec[8*(i+1) +: 8]),
      .valid       (cell_valid[i]),
      .data        (cell_flat[8*i +: 8])
    );
  end

  assign pad_valid = {{PAD_CELLS{1'b0}}, cell_valid};
  assign pad_data  = {{(8*PAD_CELLS){1'b0}}, cell_flat};

  // Held count is len + 1 (ampersand plus name) exactly when cell len is the
  // last filled cell, since the filled cells always form an unbroken run.
  logic cnt3, cnt4, cnt5;
  logic [15:0] name2;
  logic [23:0] name3;
  logic [31:0] name4;

  assign cnt3  = pad_valid[2] && !pad_valid[3];
  assign cnt4  = pad_valid[3] && !pad_valid[4];
  assign cnt5  = pad_valid[4] && !pad_valid[5];
  assign name2 = {pad_data[15:8], pad_data[23:16]};
  assign name3 = {name2, pad_data[31:24]};
  assign name4 = {name3, pad_data[39:32]};

  always_comb begin
    stat.head_valid = cell_valid[0];
    stat.next_valid = cell_valid[1];
    stat.full       = cell_valid[MAX_REF_SPAN-1];
    stat.head_data  = cell_flat[7:0];
    stat.next_data  = cell_flat[15:8];
    stat.match_hit  = 1'b1;
    stat.match_byte = CH_AMP;
    if (cnt4 && name3 == NAME_AMP) begin
      stat.match_byte = CH_AMP;
    end else if (cnt3 && name2 == NAME_LT) begin
      stat.match_byte = CH_LT;
    end else if (cnt3 && name2 == NAME_GT) begin
      stat.match_byte = CH_GT;
    end else if (cnt5 && name4 == NAME_QUOT) begin
      stat.match_byte = CH_QUOT;
    end else if (cnt5 && name4 == NAME_APOS) begin
      stat.match_byte = CH_APOS;
    end else if (cnt4 && name3 == NAME_N39) begin
      stat.match_byte = CH_APOS;
    end else if (cnt5 && name4 == NAME_NBSP) begin
      stat.match_byte = CH_SPACE;
    end else begin
      stat.match_hit = 1'b0;
    end
  end

  hed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_final  (in_final),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .text_end  (text_end),
    .stat      (stat),
    .cmd       (cmd)
  );

endmodule

>>> rtl/core/hed_checker.sv
// Port-level checks for the character reference decoder, bound to its top level.
`timescale 1ns / 1ps

module hed_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_final,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       text_end
);

  // Reset leaves no word on the output and the input side open.
  a_reset_state: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output word or busy input after reset");

  // The end of the text is always also the end of its input word's results.
  a_text_end_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> run_end)
    else $error("text_end without run_end");

  // A final word always gives at least one result, so input closes after it.
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("final word accepted without results pending");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_end)
      && $stable(text_end))
    else $error("stalled output word changed");

endmodule

bind html_entity_decoder_unit hed_checker u_hed_checker (.*);

>>> dv/html_entity_decoder_unit_tb.sv
// Self-checking testbench for the streaming HTML character reference decoder.
`timescale 1ns / 1ps

module html_entity_decoder_unit_tb;

  import hed_pkg::*;

  // Span of a reference, ampersand included. This matches the default of the unit.
  localparam int SPAN = 10;
  // Cycles without any accepted word, while work is outstanding, before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Cycles allowed after the last decoded word, for any stray word to show itself.
  localparam int SETTLE_CYCLES = 30;

  // Shapes of byte sequence used by the random traffic.
  typedef enum int {
    SK_PLAIN,
    SK_KNOWN,
    SK_NEAR_MISS,
    SK_UNKNOWN,
    SK_LONG,
    SK_BROKEN
  } seq_kind_t;

  // One decoded word as it should leave the unit.
  typedef struct packed {
    logic [7:0] ch;
    logic       last_of_word;
    logic       last_of_text;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       text_end;

  html_entity_decoder_unit #(
    .MAX_REF_SPAN(SPAN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_final (in_final),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .run_end  (run_end),
    .text_end (text_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the reference buffer: the ampersand first, then the name bytes.
  logic [7:0] held_buf [SPAN];
  int         held_len = 0;

  // Decoded words still to come out of the unit, oldest first.
  decoded_t   decoded_q [$];

  int errors = 0;
  int sent_words = 0;
  int idle_pct = 0;   // chance in a hundred that the sender idles in a cycle
  int stall_pct = 0;  // chance in a hundred that the receiver stalls in a cycle
  int quiet_cycles = 0;

  // True when the held name, after the ampersand, is exactly the given name.
  // The name is packed with its last character in the lowest byte.
  function automatic bit held_is(input logic [31:0] name, input int len);
    if (held_len != len + 1) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (held_buf[k + 1] != name[8 * (len - 1 - k) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Replacement character of the held name, or -1 when the name is not known.
  function automatic int replacement_char();
    if (held_is(32'(NAME_AMP), 3)) return int'(CH_AMP);
    if (held_is(32'(NAME_LT), 2)) return int'(CH_LT);
    if (held_is(32'(NAME_GT), 2)) return int'(CH_GT);
    if (held_is(NAME_QUOT, 4)) return int'(CH_QUOT);
    if (held_is(NAME_APOS, 4)) return int'(CH_APOS);
    if (held_is(32'(NAME_N39), 3)) return int'(CH_APOS);
    if (held_is(NAME_NBSP, 4)) return int'(CH_SPACE);
    return -1;
  endfunction

  // Works out the words that one accepted input word gives, and queues them.
  task automatic decode_word(input logic [7:0] b, input logic fin);
    logic [7:0] outs [$];
    logic [7:0] rescan [$];
    int         code;
    int         i;
    decoded_t   d;
    if (held_len == 0) begin
      if (b == CH_AMP) begin
        held_buf[0] = b;
        held_len = 1;
      end else begin
        outs = {outs, b};
      end
    end else if (b == CH_SEMI) begin
      code = replacement_char();
      if (code >= 0) begin
        outs = {outs, code[7:0]};
      end else begin
        // An unknown name goes out as it came in, semicolon included.
        for (i = 0; i < held_len; i++) outs = {outs, held_buf[i]};
        outs = {outs, b};
      end
      held_len = 0;
    end else if (held_len < SPAN) begin
      held_buf[held_len] = b;
      held_len++;
    end else begin
      // The span is exceeded: the ampersand goes out literally, and the rest is
      // scanned again up to the next ampersand, which opens a fresh reference.
      outs = {outs, held_buf[0]};
      for (i = 1; i < held_len; i++) rescan = {rescan, held_buf[i]};
      rescan = {rescan, b};
      i = 0;
      while (i < rescan.size() && rescan[i] != CH_AMP) begin
        outs = {outs, rescan[i]};
        i++;
      end
      held_len = 0;
      for (; i < rescan.size() && held_len < SPAN; i++) begin
        held_buf[held_len] = rescan[i];
        held_len++;
      end
    end
    if (fin) begin
      // End of the text: whatever is still held is flushed literally.
      for (i = 0; i < held_len; i++) outs = {outs, held_buf[i]};
      held_len = 0;
    end
    foreach (outs[j]) begin
      d.ch = outs[j];
      d.last_of_word = (j == outs.size() - 1);
      d.last_of_text = fin && (j == outs.size() - 1);
      decoded_q = {decoded_q, d};
    end
  endtask

  // Offers one word to the unit, after a random idle spell, and waits for it to
  // be taken. The task returns at the edge at which the word was accepted.
  task automatic send_word(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_final <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_word(b, fin);
    sent_words++;
  endtask

  // Sends a string of text, with the final flag on its last character if asked.
  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_word(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic send_seq(input logic [7:0] txt [$], input bit fin);
    foreach (txt[i]) send_word(txt[i], fin && (i == txt.size() - 1));
  endtask

  function automatic string entity_name(input int idx);
    case (idx)
      0: return "amp";
      1: return "lt";
      2: return "gt";
      3: return "quot";
      4: return "apos";
      5: return "#39";
      default: return "nbsp";
    endcase
  endfunction

  // A random byte that can neither open nor close a reference.
  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_AMP || b == CH_SEMI);
    return b;
  endfunction

  // Result checking. Every accepted result word is compared with the oldest
  // decoded word still waiting. The receiver also decides here, cycle by
  // cycle, whether it will stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin : check_result
        decoded_t want;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result word: out_byte %02h run_end %0b text_end %0b",
                   $time, out_byte, run_end, text_end);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.ch) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.ch, out_byte);
            errors++;
          end
          if (run_end !== want.last_of_word) begin
            $display("%0t: run_end mismatch: expected %0b, actual %0b",
                     $time, want.last_of_word, run_end);
            errors++;
          end
          if (text_end !== want.last_of_text) begin
            $display("%0t: text_end mismatch: expected %0b, actual %0b",
                     $time, want.last_of_text, text_end);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog. It counts the cycles in which work is outstanding but no word
  // moves on either side, and gives up once the count reaches the limit.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (in_valid || decoded_q.size() != 0) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word has moved for %0d cycles", $time, quiet_cycles);
        $display("** html_entity_decoder_unit: FAILED **");
        $finish;
      end
    end
  end

  // Plain bytes go straight through: both extremes of the byte, and a
  // semicolon with nothing held, which is an ordinary byte.
  task automatic test_passthrough();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_SEMI, 1'b0);
  endtask

  task automatic test_known_names();
    send_text("&lt;", 1'b0);
    send_text("&gt;", 1'b0);
  endtask

  task automatic test_unknown_name();
    send_text("&ab;", 1'b0);
  endtask

  // The buffer fills up with a second ampersand inside it. The first ampersand
  // and the bytes before the second go out literally, the second reference is
  // held again and then closed as an unknown name.
  task automatic test_span_overflow();
    send_text("&abc&defghx;", 1'b0);
  endtask

  // The end of the text arrives while a reference is still open.
  task automatic test_final_flush();
    send_text("&q", 1'b1);
  endtask

  // Random traffic: plain bytes, known names, near misses and unknown names in
  // well-formed references, long names that fill or overrun the span and broken references.
  task automatic test_random_traffic(input int n_words);
    logic [7:0] txt [$];
    int         stop_at;
    int         len;
    int         pick;
    string      name;
    seq_kind_t  kind;
    bit         fin;
    stop_at = sent_words + n_words;
    while (sent_words < stop_at) begin
      txt.delete();
      pick = $urandom_range(0, 99);
      if (pick < 25) kind = SK_PLAIN;
      else if (pick < 50) kind = SK_KNOWN;
      else if (pick < 60) kind = SK_NEAR_MISS;
      else if (pick < 72) kind = SK_UNKNOWN;
      else if (pick < 87) kind = SK_LONG;
      else kind = SK_BROKEN;
      fin = ($urandom_range(0, 99) < 8);
      case (kind)
        SK_PLAIN: begin
          len = $urandom_range(1, 4);
          repeat (len) txt = {txt, 8'($urandom_range(0, 255))};
        end
        SK_KNOWN: begin
          name = entity_name($urandom_range(0, 6));
          txt = {txt, CH_AMP};
          for (int i = 0; i < name.len(); i++) txt = {txt, name[i]};
          txt = {txt, CH_SEMI};
        end
        SK_NEAR_MISS: begin
          // A known name with one character changed in case, or cut short.
          name = entity_name($urandom_range(0, 6));
          txt = {txt, CH_AMP};
          len = $urandom_range(0, name.len() - 1);
          if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < name.len(); i++) begin
              txt = {txt, ((i == len) ? (name[i] ^ 8'h20) : name[i])};
            end
          end else begin
            for (int i = 0; i < len; i++) txt = {txt, name[i]};
          end
          txt = {txt, CH_SEMI};
        end
        SK_UNKNOWN: begin
          // Up to nine name bytes, so that the longest closes at the edge of the span.
          len = ($urandom_range(0, 3) == 0) ? SPAN - 1 : $urandom_range(0, SPAN - 1);
          txt = {txt, CH_AMP};
          repeat (len) txt = {txt, name_byte()};
          txt = {txt, CH_SEMI};
        end
        SK_LONG: begin
          // Filling the span or running past it, now and then with a further ampersand inside.
          len = $urandom_range(SPAN - 1, SPAN + 5);
          txt = {txt, CH_AMP};
          repeat (len) txt = {txt, (($urandom_range(0, 99) < 15) ? CH_AMP : name_byte())};
          if ($urandom_range(0, 1) == 0) txt = {txt, CH_SEMI};
        end
        default: begin
          // An opened reference left hanging, often ended by the end of the text.
          txt = {txt, CH_AMP};
          len = $urandom_range(0, 4);
          repeat (len) txt = {txt, 8'($urandom_range(0, 255))};
          fin = ($urandom_range(0, 1) == 0);
        end
      endcase
      send_seq(txt, fin);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed cases run with both sides always ready.
    test_passthrough();
    test_known_names();
    test_unknown_name();
    test_span_overflow();
    test_final_flush();

    // Random traffic under each idling pattern in turn.
    idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(80);
    idle_pct = 59;
    stall_pct = 0;
    test_random_traffic(80);
    idle_pct = 0;
    stall_pct = 59;
    test_random_traffic(80);
    idle_pct = 15;
    stall_pct = 15;
    test_random_traffic(80);

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && decoded_q.size() == 0) begin
      $display("** html_entity_decoder_unit: PASSED **");
    end else begin
      if (decoded_q.size() != 0) begin
        $display("%0t: %0d decoded words never arrived", $time, decoded_q.size());
      end
      $display("** html_entity_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hed_pkg.sv
rtl/core/hed_cell.sv
rtl/core/hed_ctrl.sv
rtl/core/html_entity_decoder_unit.sv
rtl/core/hed_checker.sv
dv/html_entity_decoder_unit_tb.sv
